FILE: rtl/sacf_pkg.sv
package sacf_pkg;

  // Fixed field widths
  localparam int ADDR_W   = 64;
  localparam int GAP_W    = 16;
  localparam int CNT_W    = 32;
  localparam int CYC_W    = 48;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int GP_W     = 20;  // gap_count times plain_cycles
  localparam int CHARGE_W = 21;  // cycle cost of one item
  localparam int MIN_OFF  = 6;   // smallest block offset in use

  // Default geometry
  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 4;
  localparam int ADDR_BITS_DEF = 64;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_OFFSET_BITS   = 3'd0;
  localparam logic [2:0] REG_INDEX_BITS    = 3'd1;
  localparam logic [2:0] REG_WAYS_USED     = 3'd2;
  localparam logic [2:0] REG_HIT_CYCLES    = 3'd3;
  localparam logic [2:0] REG_MEMORY_CYCLES = 3'd4;
  localparam logic [2:0] REG_PLAIN_CYCLES  = 3'd5;

  // Register reset values
  localparam logic [4:0] OFFSET_BITS_RST   = 5'd6;
  localparam logic [2:0] INDEX_BITS_RST    = 3'd6;
  localparam logic [2:0] WAYS_USED_RST     = 3'd4;
  localparam logic [7:0] HIT_CYCLES_RST    = 8'd5;
  localparam logic [9:0] MEMORY_CYCLES_RST = 10'd100;
  localparam logic [3:0] PLAIN_CYCLES_RST  = 4'd1;

  typedef struct packed {
    logic [4:0] offset_bits;
    logic [2:0] index_bits;
    logic [2:0] ways_used;
    logic [7:0] hit_cycles;
    logic [9:0] memory_cycles;
    logic [3:0] plain_cycles;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;  // write one metadata row of the clearing pass
    logic take;   // latch the input item
    logic look;   // split the address and read the set
    logic upd;    // compare tags and write the set back
    logic fin;    // update totals and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sacf_if.sv
interface sacf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [sacf_pkg::ADDR_W-1:0]   address;
  logic [sacf_pkg::GAP_W-1:0]    gap_count;

  modport source (output valid, action, address, gap_count, input ready);
  modport sink (input valid, action, address, gap_count, output ready);
endinterface

interface sacf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          writeback;
  logic [sacf_pkg::ADDR_W-1:0]   writeback_address;
  logic [sacf_pkg::CNT_W-1:0]    hit_total;
  logic [sacf_pkg::CNT_W-1:0]    miss_total;
  logic [sacf_pkg::CNT_W-1:0]    memory_access_total;
  logic [sacf_pkg::CYC_W-1:0]    cycle_total;

  modport source (output valid, hit, writeback, writeback_address, hit_total, miss_total,
                  memory_access_total, cycle_total, input ready);
  modport sink (input valid, hit, writeback, writeback_address, hit_total, miss_total,
                memory_access_total, cycle_total, output ready);
endinterface

FILE: rtl/set_assoc_cache_fifo_model_core.sv
// Tag-only model of a write-back, write-allocate set-associative cache with FIFO
// replacement and saturating hit, miss, memory-access and cycle totals.
// Input channel in_if carries one access per item (action, address, gap_count);
// output channel out_if returns exactly one result item per access, in order.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// The configuration registers sit on an APB-style port at byte address 4*index
// and are meant to be written only while no access is in flight.
// An access moves through the look, update and done states, and is loaded into the
// result register once that is free; no new access is taken until then, due to the
// read-modify-write of the set storage (read tags and metadata, compare, write back).
// Reset is synchronous and active low. After reset a clearing pass zeroes the
// valid, dirty and FIFO pointer bits of every set, one set per cycle; no
// access is accepted during it, while register writes are taken as usual.
// The result register lets a new access be accepted while a result still waits;
// if the receiver stalls, the next result is held back and input stays blocked
// until the waiting result is taken.
module set_assoc_cache_fifo_model_core #(
  parameter int SETS      = sacf_pkg::SETS_DEF,
  parameter int WAYS      = sacf_pkg::WAYS_DEF,
  parameter int ADDR_BITS = sacf_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sacf_in_if.sink                        in_if,
  sacf_out_if.source                     out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sacf_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacf_pkg::PDATA_W-1:0]   pwdata,
  output logic [sacf_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  sacf_pkg::cfg_t cfg;
  sacf_pkg::cmd_t cmd;
  sacf_pkg::sts_t sts;
  logic           in_ready;

  sacf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sacf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_if.ready = in_ready;

  sacf_dp #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_action               (in_if.action),
    .in_address              (in_if.address),
    .in_gap_count            (in_if.gap_count),
    .out_valid               (out_if.valid),
    .out_ready               (out_if.ready),
    .out_hit                 (out_if.hit),
    .out_writeback           (out_if.writeback),
    .out_writeback_address   (out_if.writeback_address),
    .out_hit_total           (out_if.hit_total),
    .out_miss_total          (out_if.miss_total),
    .out_memory_access_total (out_if.memory_access_total),
    .out_cycle_total         (out_if.cycle_total)
  );

endmodule

FILE: rtl/sacf_cfg.sv
module sacf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sacf_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacf_pkg::PDATA_W-1:0]   pwdata,
  output logic [sacf_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output sacf_pkg::cfg_t                 cfg
);

  sacf_pkg::cfg_t cfg_r;
  sacf_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[sacf_pkg::PADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        sacf_pkg::REG_OFFSET_BITS:   cfg_nxt.offset_bits   = pwdata[4:0];
        sacf_pkg::REG_INDEX_BITS:    cfg_nxt.index_bits    = pwdata[2:0];
        sacf_pkg::REG_WAYS_USED:     cfg_nxt.ways_used     = pwdata[2:0];
        sacf_pkg::REG_HIT_CYCLES:    cfg_nxt.hit_cycles    = pwdata[7:0];
        sacf_pkg::REG_MEMORY_CYCLES: cfg_nxt.memory_cycles = pwdata[9:0];
        sacf_pkg::REG_PLAIN_CYCLES:  cfg_nxt.plain_cycles  = pwdata[3:0];
        default:                     cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sacf_pkg::REG_OFFSET_BITS:   prdata = {27'd0, cfg_r.offset_bits};
      sacf_pkg::REG_INDEX_BITS:    prdata = {29'd0, cfg_r.index_bits};
      sacf_pkg::REG_WAYS_USED:     prdata = {29'd0, cfg_r.ways_used};
      sacf_pkg::REG_HIT_CYCLES:    prdata = {24'd0, cfg_r.hit_cycles};
      sacf_pkg::REG_MEMORY_CYCLES: prdata = {22'd0, cfg_r.memory_cycles};
      sacf_pkg::REG_PLAIN_CYCLES:  prdata = {28'd0, cfg_r.plain_cycles};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits   <= sacf_pkg::OFFSET_BITS_RST;
      cfg_r.index_bits    <= sacf_pkg::INDEX_BITS_RST;
      cfg_r.ways_used     <= sacf_pkg::WAYS_USED_RST;
      cfg_r.hit_cycles    <= sacf_pkg::HIT_CYCLES_RST;
      cfg_r.memory_cycles <= sacf_pkg::MEMORY_CYCLES_RST;
      cfg_r.plain_cycles  <= sacf_pkg::PLAIN_CYCLES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/sacf_ctrl.sv
module sacf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output sacf_pkg::cmd_t cmd,
  input  sacf_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cmd.clear = (state_r == ST_CLEAR);
  assign cmd.take  = (state_r == ST_IDLE) && in_valid;
  assign cmd.look  = (state_r == ST_LOOK);
  assign cmd.upd   = (state_r == ST_UPD);
  assign cmd.fin   = (state_r == ST_DONE) && sts.out_free;

  // Once the metadata is cleared, only a reset starts the pass again.
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> state_r != ST_CLEAR)
    else $error("clearing pass re-entered without reset");

  // An accepted item passes through the look and update states to the result stage.
  a_item_flow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> ##3 state_r == ST_DONE)
    else $error("accepted item did not reach the result stage");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

FILE: rtl/sacf_dp.sv
module sacf_dp #(
  parameter int SETS      = sacf_pkg::SETS_DEF,
  parameter int WAYS      = sacf_pkg::WAYS_DEF,
  parameter int ADDR_BITS = sacf_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sacf_pkg::cfg_t                 cfg,
  input  sacf_pkg::cmd_t                 cmd,
  output sacf_pkg::sts_t                 sts,
  input  logic                           in_action,
  input  logic [sacf_pkg::ADDR_W-1:0]    in_address,
  input  logic [sacf_pkg::GAP_W-1:0]     in_gap_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic                           out_writeback,
  output logic [sacf_pkg::ADDR_W-1:0]    out_writeback_address,
  output logic [sacf_pkg::CNT_W-1:0]     out_hit_total,
  output logic [sacf_pkg::CNT_W-1:0]     out_miss_total,
  output logic [sacf_pkg::CNT_W-1:0]     out_memory_access_total,
  output logic [sacf_pkg::CYC_W-1:0]     out_cycle_total
);

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int IDX_MAX = $clog2(SETS + 1) - 1;
  localparam int WCNT_W  = $clog2(WAYS + 1);
  localparam int PTR_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W   = ADDR_BITS - sacf_pkg::MIN_OFF;
  localparam int ROW_W   = WAYS * TAG_W;
  localparam int AW      = sacf_pkg::ADDR_W;
  localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}} >> (AW - ADDR_BITS);

  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic [WAYS-1:0]  dirty;
    logic [WAYS-1:0]  valid;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // Set storage: tags have no reset, metadata is cleared by a sweep after reset.
  logic [ROW_W-1:0]  tag_mem  [SETS];
  logic [META_W-1:0] meta_mem [SETS];

  logic [SET_W-1:0]               clr_r;
  logic                           act_r;
  logic [AW-1:0]                  addr_r;
  logic [sacf_pkg::GAP_W-1:0]     gap_r;
  logic [SET_W-1:0]               set_r;
  logic [TAG_W-1:0]               tag_r;
  logic [sacf_pkg::GP_W-1:0]      gp_r;
  logic [ROW_W-1:0]               tag_q_r;
  meta_t                          meta_q_r;
  logic                           hit_r;
  logic                           wb_r;
  logic [TAG_W-1:0]               wb_tag_r;
  logic [sacf_pkg::CNT_W-1:0]     hits_r;
  logic [sacf_pkg::CNT_W-1:0]     misses_r;
  logic [sacf_pkg::CNT_W-1:0]     mem_r;
  logic [sacf_pkg::CYC_W-1:0]     cycles_r;
  logic [sacf_pkg::CNT_W-1:0]     hits_nxt;
  logic [sacf_pkg::CNT_W-1:0]     misses_nxt;
  logic [sacf_pkg::CNT_W-1:0]     mem_nxt;
  logic [sacf_pkg::CYC_W-1:0]     cycles_nxt;
  logic                           out_valid_r;
  logic                           out_hit_r;
  logic                           out_wb_r;
  logic [AW-1:0]                  out_wb_addr_r;

  // Effective geometry
  logic [4:0]        off_eff;
  logic [2:0]        idx_eff;
  logic [5:0]        hi;
  logic [WCNT_W-1:0] ways_eff;

  always_comb begin
    off_eff = (cfg.offset_bits < 5'(sacf_pkg::MIN_OFF)) ? 5'(sacf_pkg::MIN_OFF)
                                                        : cfg.offset_bits;
    idx_eff = (int'(cfg.index_bits) > IDX_MAX) ? 3'(IDX_MAX) : cfg.index_bits;
    hi      = 6'(off_eff) + 6'(idx_eff);
    if (cfg.ways_used == 3'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(cfg.ways_used) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg.ways_used);
    end
  end

  // Address split
  logic [AW-1:0]    sh_off;
  logic [AW-1:0]    sh_hi;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_c;

  always_comb begin
    sh_off   = addr_r >> off_eff;
    sh_hi    = sh_off >> idx_eff;
    set_mask = (SET_W'(1) << idx_eff) - SET_W'(1);
    set_c    = sh_off[SET_W-1:0] & set_mask;
  end

  // Lookup and replacement on the row read back from the set storage
  logic             hit_c;
  logic             free_c;
  logic             wb_c;
  logic [PTR_W-1:0] hit_way;
  logic [PTR_W-1:0] free_way;
  logic [PTR_W-1:0] vict;
  logic [PTR_W-1:0] way_c;
  logic [WCNT_W-1:0] vict_inc;
  meta_t            meta_new;
  logic [ROW_W-1:0] row_new;

  always_comb begin
    hit_c    = 1'b0;
    free_c   = 1'b0;
    hit_way  = '0;
    free_way = '0;
    // Scan downward so that the lowest matching or free way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (WCNT_W'(w) < ways_eff) begin
        if (meta_q_r.valid[w] && (tag_q_r[w*TAG_W +: TAG_W] == tag_r)) begin
          hit_c   = 1'b1;
          hit_way = PTR_W'(w);
        end
        if (!meta_q_r.valid[w]) begin
          free_c   = 1'b1;
          free_way = PTR_W'(w);
        end
      end
    end
    // A stale pointer beyond the ways in use falls back to way zero.
    vict     = (WCNT_W'(meta_q_r.ptr) >= ways_eff) ? '0 : meta_q_r.ptr;
    vict_inc = WCNT_W'(vict) + WCNT_W'(1);
    if (hit_c) begin
      way_c = hit_way;
    end else if (free_c) begin
      way_c = free_way;
    end else begin
      way_c = vict;
    end
    wb_c     = !hit_c && !free_c && meta_q_r.dirty[vict];
    meta_new = meta_q_r;
    row_new  = tag_q_r;
    if (!hit_c) begin
      meta_new.valid[way_c] = 1'b1;
      meta_new.dirty[way_c] = 1'b0;
      row_new[way_c*TAG_W +: TAG_W] = tag_r;
      if (!free_c) begin
        meta_new.ptr = (vict_inc >= ways_eff) ? '0 : vict_inc[PTR_W-1:0];
      end
    end
    if (act_r) begin
      meta_new.dirty[way_c] = 1'b1;
    end
  end

  // Set storage ports
  always_ff @(posedge clk) begin
    if (cmd.upd && !hit_c) begin
      tag_mem[set_r] <= row_new;
    end
    if (cmd.look) begin
      tag_q_r <= tag_mem[set_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_r] <= '0;
    end else if (cmd.upd) begin
      meta_mem[set_r] <= meta_new;
    end
    if (cmd.look) begin
      meta_q_r <= meta_mem[set_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + SET_W'(1);
    end
  end

  assign sts.clr_last = (clr_r == SET_W'(SETS - 1));

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r  <= in_action;
      addr_r <= in_address & ADDR_MASK;
      gap_r  <= in_gap_count;
    end
    if (cmd.look) begin
      set_r <= set_c;
      tag_r <= sh_hi[TAG_W-1:0];
      gp_r  <= sacf_pkg::GP_W'(gap_r) * sacf_pkg::GP_W'(cfg.plain_cycles);
    end
    if (cmd.upd) begin
      hit_r    <= hit_c;
      wb_r     <= wb_c;
      wb_tag_r <= tag_q_r[vict*TAG_W +: TAG_W];
    end
  end

  // Totals and result
  logic [sacf_pkg::CHARGE_W-1:0] mem_term;
  logic [sacf_pkg::CHARGE_W-1:0] charge;
  logic [1:0]                    n_mem;
  logic [sacf_pkg::CNT_W:0]      hits_sum;
  logic [sacf_pkg::CNT_W:0]      misses_sum;
  logic [sacf_pkg::CNT_W:0]      mem_sum;
  logic [sacf_pkg::CYC_W:0]      cycles_sum;
  logic [AW-1:0]                 wb_addr_c;

  always_comb begin
    n_mem = {1'b0, !hit_r} + {1'b0, wb_r};
    if (hit_r) begin
      mem_term = '0;
    end else if (wb_r) begin
      mem_term = {sacf_pkg::CHARGE_W'(cfg.memory_cycles)} << 1;
    end else begin
      mem_term = sacf_pkg::CHARGE_W'(cfg.memory_cycles);
    end
    charge = sacf_pkg::CHARGE_W'(cfg.hit_cycles) + sacf_pkg::CHARGE_W'(gp_r) + mem_term;
    // Costs are never negative, so one saturating add per item matches step-by-step
    // saturation.
    hits_sum   = {1'b0, hits_r} + (sacf_pkg::CNT_W + 1)'(hit_r);
    misses_sum = {1'b0, misses_r} + (sacf_pkg::CNT_W + 1)'(!hit_r);
    mem_sum    = {1'b0, mem_r} + (sacf_pkg::CNT_W + 1)'(n_mem);
    cycles_sum = {1'b0, cycles_r} + (sacf_pkg::CYC_W + 1)'(charge);
    hits_nxt   = hits_sum[sacf_pkg::CNT_W] ? '1 : hits_sum[sacf_pkg::CNT_W-1:0];
    misses_nxt = misses_sum[sacf_pkg::CNT_W] ? '1 : misses_sum[sacf_pkg::CNT_W-1:0];
    mem_nxt    = mem_sum[sacf_pkg::CNT_W] ? '1 : mem_sum[sacf_pkg::CNT_W-1:0];
    cycles_nxt = cycles_sum[sacf_pkg::CYC_W] ? '1 : cycles_sum[sacf_pkg::CYC_W-1:0];
    wb_addr_c  = ((AW'(wb_tag_r) << hi) | (AW'(set_r) << off_eff)) & ADDR_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      mem_r    <= '0;
      cycles_r <= '0;
    end else if (cmd.fin) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      mem_r    <= mem_nxt;
      cycles_r <= cycles_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_hit_r     <= hit_r;
      out_wb_r      <= wb_r;
      out_wb_addr_r <= wb_r ? wb_addr_c : '0;
    end
  end

  assign sts.out_free            = !out_valid_r || out_ready;
  assign out_valid               = out_valid_r;
  assign out_hit                 = out_hit_r;
  assign out_writeback           = out_wb_r;
  assign out_writeback_address   = out_wb_addr_r;
  assign out_hit_total           = hits_r;
  assign out_miss_total          = misses_r;
  assign out_memory_access_total = mem_r;
  assign out_cycle_total         = cycles_r;

  // Every miss costs a fetch, so memory traffic never trails the miss count.
  a_mem_ge_miss: assert property (@(posedge clk) disable iff (!rst_n)
    mem_r >= misses_r)
    else $error("memory access total below miss total");

  a_hits_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hits_r >= $past(hits_r))
    else $error("hit total decreased");

  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wb_r |-> !out_hit_r)
    else $error("writeback reported on a hit");

endmodule

FILE: sim/testbench.sv
typedef struct packed {
  logic                        hit;
  logic                        writeback;
  logic [sacf_pkg::ADDR_W-1:0] writeback_address;
  logic [sacf_pkg::CNT_W-1:0]  hit_total;
  logic [sacf_pkg::CNT_W-1:0]  miss_total;
  logic [sacf_pkg::CNT_W-1:0]  memory_access_total;
  logic [sacf_pkg::CYC_W-1:0]  cycle_total;
} access_outcome_t;

// Shadow copy of the tag array, replacement pointers and totals. Each accepted
// access is applied here, and the outcome it must produce is queued in order.
class tag_cache_shadow;
  localparam int NSETS = sacf_pkg::SETS_DEF;
  localparam int NWAYS = sacf_pkg::WAYS_DEF;
  localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

  sacf_pkg::cfg_t  regs;
  logic [63:0]     line_tag [NSETS*NWAYS];
  bit              line_valid [NSETS*NWAYS];
  bit              line_dirty [NSETS*NWAYS];
  int              fifo_ptr [NSETS];
  logic [63:0]     hit_tally;
  logic [63:0]     miss_tally;
  logic [63:0]     mem_count;
  logic [63:0]     cycle_count;
  access_outcome_t access_outcomes[$];
  int              mismatches;

  function new();
    regs.offset_bits   = sacf_pkg::OFFSET_BITS_RST;
    regs.index_bits    = sacf_pkg::INDEX_BITS_RST;
    regs.ways_used     = sacf_pkg::WAYS_USED_RST;
    regs.hit_cycles    = sacf_pkg::HIT_CYCLES_RST;
    regs.memory_cycles = sacf_pkg::MEMORY_CYCLES_RST;
    regs.plain_cycles  = sacf_pkg::PLAIN_CYCLES_RST;
    foreach (line_tag[i]) begin
      line_tag[i] = '0;
      line_valid[i] = 0;
      line_dirty[i] = 0;
    end
    foreach (fifo_ptr[i]) fifo_ptr[i] = 0;
    hit_tally = 0;
    miss_tally = 0;
    mem_count = 0;
    cycle_count = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      sacf_pkg::REG_OFFSET_BITS:   regs.offset_bits = value[4:0];
      sacf_pkg::REG_INDEX_BITS:    regs.index_bits = value[2:0];
      sacf_pkg::REG_WAYS_USED:     regs.ways_used = value[2:0];
      sacf_pkg::REG_HIT_CYCLES:    regs.hit_cycles = value[7:0];
      sacf_pkg::REG_MEMORY_CYCLES: regs.memory_cycles = value[9:0];
      sacf_pkg::REG_PLAIN_CYCLES:  regs.plain_cycles = value[3:0];
      default: ;
    endcase
  endfunction

  function int eff_offset();
    return (regs.offset_bits < sacf_pkg::MIN_OFF) ? sacf_pkg::MIN_OFF : int'(regs.offset_bits);
  endfunction

  function int eff_index();
    int n;
    n = regs.index_bits;
    while (n > 0 && (1 << n) > NSETS) n--;
    return n;
  endfunction

  function int eff_ways();
    int n;
    n = regs.ways_used;
    if (n == 0) n = 1;
    if (n > NWAYS) n = NWAYS;
    return n;
  endfunction

  function logic [63:0] sat(logic [63:0] value, logic [63:0] limit);
    return (value > limit) ? limit : value;
  endfunction

  function void note_access(logic store, logic [63:0] addr, logic [15:0] gap);
    int off, idx, ways, set_idx, base, way, w, p;
    logic [63:0] tag, charge, mem_ops;
    bit hit, found;
    access_outcome_t r;
    off = eff_offset();
    idx = eff_index();
    ways = eff_ways();
    set_idx = int'((addr >> off) & ((64'd1 << idx) - 64'd1));
    tag = addr >> (off + idx);
    base = set_idx * NWAYS;
    r = '0;
    hit = 0;
    found = 0;
    way = 0;
    mem_ops = 0;
    for (w = 0; w < ways; w++) begin
      if (!hit && line_valid[base+w] && line_tag[base+w] == tag) begin
        hit = 1;
        way = w;
      end
    end
    if (hit) begin
      hit_tally = sat(hit_tally + 1, MAX32);
    end else begin
      miss_tally = sat(miss_tally + 1, MAX32);
      for (w = 0; w < ways; w++) begin
        if (!found && !line_valid[base+w]) begin
          found = 1;
          way = w;
        end
      end
      if (!found) begin
        // A pointer left over from a wider way setting falls back to way 0.
        p = fifo_ptr[set_idx];
        if (p >= ways) p = 0;
        way = p;
        if (line_dirty[base+way]) begin
          r.writeback = 1;
          r.writeback_address = (line_tag[base+way] << (off + idx)) | (64'(set_idx) << off);
          mem_ops++;
        end
        fifo_ptr[set_idx] = (p + 1 >= ways) ? 0 : p + 1;
      end
      mem_ops++;
      line_tag[base+way] = tag;
      line_valid[base+way] = 1;
      line_dirty[base+way] = 0;
    end
    if (store) line_dirty[base+way] = 1;
    // All charges are non-negative, so one saturating add equals the stepwise ones.
    charge = 64'(regs.hit_cycles) + mem_ops * 64'(regs.memory_cycles)
             + 64'(gap) * 64'(regs.plain_cycles);
    mem_count = sat(mem_count + mem_ops, MAX32);
    cycle_count = sat(cycle_count + charge, MAX48);
    r.hit = hit;
    r.hit_total = hit_tally[31:0];
    r.miss_total = miss_tally[31:0];
    r.memory_access_total = mem_count[31:0];
    r.cycle_total = cycle_count[47:0];
    access_outcomes.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 100) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(access_outcome_t got);
    access_outcome_t want;
    if (access_outcomes.size() == 0) begin
      if (mismatches < 100) $error("result item arrived with no access outstanding");
      mismatches++;
      return;
    end
    want = access_outcomes.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("writeback", want.writeback, got.writeback);
    compare_field("writeback_address", want.writeback_address, got.writeback_address);
    compare_field("hit_total", want.hit_total, got.hit_total);
    compare_field("miss_total", want.miss_total, got.miss_total);
    compare_field("memory_access_total", want.memory_access_total, got.memory_access_total);
    compare_field("cycle_total", want.cycle_total, got.cycle_total);
  endfunction
endclass

module testbench;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_STORE = 1'b1;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   PHASES = 16;
  localparam int   PHASE_ITEMS = 100;

  logic                          clk;
  logic                          rst_n;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [sacf_pkg::PADDR_W-1:0]  paddr;
  logic [sacf_pkg::PDATA_W-1:0]  pwdata;
  logic [sacf_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic [15:0]                   ready_pattern;
  logic [3:0]                    ready_phase = '0;
  int                            cycle_no = 0;
  access_outcome_t               seen;
  tag_cache_shadow               shadow;

  sacf_in_if  in_ch ();
  sacf_out_if out_ch ();

  set_assoc_cache_fifo_model_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls on a rotating 16-bit pattern chosen per phase.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 4'd1;
    out_ch.ready <= ready_pattern[ready_phase];
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.hit = out_ch.hit;
      seen.writeback = out_ch.writeback;
      seen.writeback_address = out_ch.writeback_address;
      seen.hit_total = out_ch.hit_total;
      seen.miss_total = out_ch.miss_total;
      seen.memory_access_total = out_ch.memory_access_total;
      seen.cycle_total = out_ch.cycle_total;
      shadow.check_result(seen);
    end
  end

  task automatic push_access(logic store, logic [63:0] addr, logic [15:0] gap);
    in_ch.valid <= 1'b1;
    in_ch.action <= store;
    in_ch.address <= addr;
    in_ch.gap_count <= gap;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_access(store, addr, gap);
  endtask

  // Leaves psel and penable up so that back-to-back writes need no extra step.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.set_reg(idx, value);
  endtask

  task automatic drain();
    while (shadow.access_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_config(int phase, output sacf_pkg::cfg_t c);
    case (phase)
      0: c = '{5'd0, 3'd0, 3'd1, 8'd0, 10'd0, 4'd0};
      1: c = '{5'd31, 3'd7, 3'd7, 8'd255, 10'd1023, 4'd15};
      2: c = '{5'd16, 3'd6, 3'd4, 8'd255, 10'd1023, 4'd15};
      // Same geometry with fewer ways leaves pointers beyond the ways in use.
      3: c = '{5'd16, 3'd6, 3'd2, 8'd17, 10'd300, 4'd3};
      4: c = '{5'd5, 3'd3, 3'd0, 8'd8, 10'd50, 4'd2};
      5: c = '{5'd6, 3'd6, 3'd5, 8'd5, 10'd100, 4'd1};
      default: begin
        c.offset_bits = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(6, 16))
                                                    : 5'($urandom_range(0, 31));
        c.index_bits = 3'($urandom_range(0, 7));
        c.ways_used = 3'($urandom_range(0, 7));
        c.hit_cycles = 8'($urandom_range(0, 255));
        c.memory_cycles = 10'($urandom_range(0, 1023));
        c.plain_cycles = 4'($urandom_range(0, 15));
      end
    endcase
  endtask

  task automatic run_phase(int n_items);
    logic [63:0] tag_pool [6];
    int          set_pool [3];
    int          off, idx, left, burst, pause, k, set_idx;
    logic [63:0] addr;
    logic [15:0] gap;
    off = shadow.eff_offset();
    idx = shadow.eff_index();
    for (k = 0; k < 6; k++) begin
      tag_pool[k] = (k < 4) ? 64'($urandom_range(0, 5)) : {$urandom, $urandom};
    end
    for (k = 0; k < 3; k++) set_pool[k] = $urandom_range(0, (1 << idx) - 1);
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (k = 0; k < burst && left > 0; k++) begin
        // Mostly a few tags on a few sets, so that hits and evictions are common.
        if ($urandom_range(0, 99) < 85) begin
          set_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << idx) - 1)
                                                : set_pool[$urandom_range(0, 2)];
          addr = (tag_pool[$urandom_range(0, 5)] << (off + idx)) | (64'(set_idx) << off)
                 | ({$urandom, $urandom} & ((64'd1 << off) - 64'd1));
        end else begin
          addr = {$urandom, $urandom};
        end
        case ($urandom_range(0, 5))
          0: gap = 16'h0000;
          1: gap = 16'hFFFF;
          2: gap = 16'($urandom);
          default: gap = 16'($urandom_range(0, 40));
        endcase
        push_access($urandom_range(0, 1) ? ACT_STORE : ACT_LOAD, addr, gap);
        left--;
      end
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (pause > 0) begin
        in_ch.valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    sacf_pkg::cfg_t c;
    int             phase;
    shadow = new();
    ready_pattern <= 16'hFFFF;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LOAD;
    in_ch.address <= '0;
    in_ch.gap_count <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: 64-byte blocks, 64 sets, 4 ways, so the tag starts at bit 12.
    push_access(ACT_LOAD, 64'h0, 16'h0000);
    push_access(ACT_LOAD, 64'h3F, 16'hFFFF);
    push_access(ACT_STORE, 64'h1000, 16'h0000);
    push_access(ACT_STORE, 64'h2000, 16'h0001);
    push_access(ACT_STORE, 64'h3000, 16'h0002);
    // Set 0 is full now; the oldest line is clean, then the next one is dirty.
    push_access(ACT_STORE, 64'h4000, 16'h0000);
    push_access(ACT_LOAD, 64'h5000, 16'h0000);
    push_access(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    push_access(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    push_access(ACT_STORE, 64'h6000, 16'h0000);
    push_access(ACT_LOAD, 64'h0, 16'h0000);
    push_access(ACT_LOAD, 64'h4000, 16'h0007);
    // Fill set 63 behind the all-ones line so its write-back carries every tag bit.
    push_access(ACT_LOAD, 64'h1FC0, 16'h0000);
    push_access(ACT_STORE, 64'h2FC0, 16'h0000);
    push_access(ACT_LOAD, 64'h3FC0, 16'h0000);
    push_access(ACT_LOAD, 64'h4FC0, 16'h0003);
    push_access(ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
    push_access(ACT_LOAD, 64'h5555_5555_5555_5555, 16'hAAAA);
    in_ch.valid <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      pick_config(phase, c);
      write_reg(sacf_pkg::REG_OFFSET_BITS, 32'(c.offset_bits));
      write_reg(sacf_pkg::REG_INDEX_BITS, 32'(c.index_bits));
      write_reg(sacf_pkg::REG_WAYS_USED, 32'(c.ways_used));
      write_reg(sacf_pkg::REG_HIT_CYCLES, 32'(c.hit_cycles));
      write_reg(sacf_pkg::REG_MEMORY_CYCLES, 32'(c.memory_cycles));
      write_reg(sacf_pkg::REG_PLAIN_CYCLES, 32'(c.plain_cycles));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      @(posedge clk);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (12) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.access_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
